### hw/rtl/mlbpg_pkg.sv
// Shared types and constants for the multi-LED blink pattern generator.
// Holds timing constants, input mode and FSM codes, and the per-LED memory entry.
// No dependencies.
`default_nettype none

package mlbpg_pkg;

  // Default number of LED pins
  parameter int unsigned LED_COUNT_DEF = 16;

  // Timing constants
  parameter int unsigned TICK_MS           = 10;
  parameter int unsigned UPDATE_TICKS      = 5;
  parameter int unsigned SINGLE_HALF_TICKS = 5;
  parameter int unsigned SINGLE_TOGGLES    = 2;
  parameter int unsigned DOUBLE_TOGGLES    = 2;

  // Half period codes with immediate effect
  localparam logic [15:0] CONST_OFF = 16'h0000;
  localparam logic [15:0] CONST_ON  = 16'hFFFF;

  // Reciprocal for ms-to-tick conversion: q ~= (x * DIV_RECIP) >> 32, one fix-up step
  localparam logic [31:0] DIV_RECIP = 32'(64'hFFFF_FFFF / 64'(TICK_MS));

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LED_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING          = 2'd1;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_PERIOD = 2'd1,
    MODE_BLINK  = 2'd2
  } mode_e;

  // Control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_CMD_RD,
    ST_CMD_WR,
    ST_DONE
  } state_e;

  // Per-LED state held in memory (pin level lives in flops)
  typedef struct packed {
    logic        sq_phase;
    logic [15:0] half_ticks;
    logic [15:0] dbl_ticks;
    logic [15:0] sq_cnt;
    logic        dbl_act;
    logic [15:0] dbl_cnt;
    logic [7:0]  dbl_tog;
    logic [15:0] pend_half;
    logic [15:0] pend_dbl;
    logic        pend_flag;
    logic        sgl_act;
    logic [15:0] sgl_cnt;
    logic [7:0]  sgl_tog;
  } led_entry_t;

  // Off and on periods bypass the blink counters
  function automatic logic is_constant(input logic [15:0] p);
    return p inside {CONST_OFF, CONST_ON};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/multi_led_blink_pattern_generator_top.sv
// Multi-LED blink pattern generator, top level.
// Uses mlbpg_pkg for constants, codes and the per-LED memory entry type.
// Running ticks visit n = min(active_led_count, LED_COUNT) entries, one per cycle, through one
//   memory read port; a new item is taken only once the last result is in the output register.
// Period and blink items: read-modify-write of one entry in the command read and write states.
// Other items (stopped, n = 0, bad index, unknown mode) go straight to the done state.
// Reset clears control and pin state; unwritten memory entries read as zero via valid bits.
`default_nettype none

module multi_led_blink_pattern_generator_top #(
  parameter int unsigned LED_COUNT = mlbpg_pkg::LED_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input items
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [3:0]                       led_index_i,
  input  wire logic [15:0]                      half_period_ms_i,
  input  wire logic [15:0]                      double_blink_ms_i,
  // result items
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [15:0]                           pin_levels_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mlbpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mlbpg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned CntW = $clog2(LED_COUNT + 1);

  // Control and payload registers
  mlbpg_pkg::state_e     state_q, state_d;
  logic [1:0]            mode_q, mode_d;
  logic [3:0]            cmd_idx_q, cmd_idx_d;
  logic [15:0]           half_q, half_d;
  logic [15:0]           div_q, div_d;
  logic                  apply_q, apply_d;
  logic [CntW-1:0]       n_q, n_d;
  logic [CntW-1:0]       scan_q, scan_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic [47:0]           prod_half_q, prod_dbl_q;
  logic [LED_COUNT-1:0]  pin_q;
  logic [LED_COUNT-1:0]  ent_vld_q;
  logic                  rd_ent_vld_q;
  logic                  out_valid_q, out_valid_d;
  logic [15:0]           pin_levels_q, pin_levels_d;
  logic [4:0]            active_q;
  logic                  running_q;

  // Memory and its ports
  mlbpg_pkg::led_entry_t led_mem_q [LED_COUNT];
  mlbpg_pkg::led_entry_t rd_data_q;
  mlbpg_pkg::led_entry_t rd_entry;
  mlbpg_pkg::led_entry_t mem_wdata;
  mlbpg_pkg::led_entry_t tk_e, cm_e;
  logic                  mem_re, mem_we;
  logic [IdxW-1:0]       mem_raddr, mem_waddr;
  logic                  pin_we, pin_wval;
  logic                  tk_pin, cm_pin;

  // Misc combinational values
  logic [CntW-1:0]       n_lim;
  logic                  idx_ok;
  logic                  accept;
  logic [15:0]           div_inc;
  logic [15:0]           quo_half, quo_dbl;
  logic [15:0]           q0_half, q0_dbl;
  logic [25:0]           rem_half, rem_dbl;
  logic [15:0]           pin_vec;
  logic [IdxW-1:0]       cmd_addr;

  assign in_ready_o   = (state_q == mlbpg_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign pin_levels_o = pin_levels_q;
  assign cfg_ready_o  = 1'b1;
  assign cmd_addr     = IdxW'(cmd_idx_q);

  // Number of LEDs visited per tick
  always_comb begin
    if (7'(active_q) >= 7'(LED_COUNT)) begin
      n_lim = CntW'(LED_COUNT);
    end else begin
      n_lim = CntW'(active_q);
    end
  end

  assign idx_ok  = 7'(led_index_i) < 7'(LED_COUNT);
  assign div_inc = div_q + 16'd1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      running_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == mlbpg_pkg::CFG_ACTIVE_LED_COUNT) begin
        active_q <= cfg_data_i[4:0];
      end else if (cfg_index_i == mlbpg_pkg::CFG_RUNNING) begin
        running_q <= cfg_data_i[0];
      end
    end
  end

  // ms-to-tick conversion: reciprocal estimate is exact or one low
  assign q0_half  = prod_half_q[47:32];
  assign q0_dbl   = prod_dbl_q[47:32];
  assign rem_half = 26'(half_q) - 26'(q0_half) * 26'(mlbpg_pkg::TICK_MS);
  assign rem_dbl  = 26'(prod_dbl_q[15:0]) - 26'(q0_dbl) * 26'(mlbpg_pkg::TICK_MS);
  assign quo_half = q0_half + 16'(rem_half >= 26'(mlbpg_pkg::TICK_MS));
  assign quo_dbl  = q0_dbl + 16'(rem_dbl >= 26'(mlbpg_pkg::TICK_MS));

  // Entry seen through valid bits
  assign rd_entry = rd_ent_vld_q ? rd_data_q : '0;

  // Per-LED tick update: square wave, one-shot, double blink, then pending apply
  always_comb begin
    tk_e   = rd_entry;
    tk_pin = pin_q[rd_idx_q];
    // square wave
    if (!mlbpg_pkg::is_constant(tk_e.half_ticks)) begin
      tk_e.sq_cnt = tk_e.sq_cnt + 16'd1;
      if (tk_e.sq_cnt >= tk_e.half_ticks) begin
        tk_e.sq_phase = ~tk_e.sq_phase;
        tk_pin        = tk_e.sq_phase;
        tk_e.sq_cnt   = '0;
        if ((tk_e.dbl_ticks != '0) && tk_e.sq_phase) begin
          tk_e.dbl_act = 1'b1;
          tk_e.dbl_cnt = '0;
          tk_e.dbl_tog = '0;
        end else begin
          tk_e.dbl_act = 1'b0;
        end
      end
    end
    // one-shot burst
    if (tk_e.sgl_act) begin
      tk_e.sgl_cnt = tk_e.sgl_cnt + 16'd1;
      if (tk_e.sgl_cnt >= 16'(mlbpg_pkg::SINGLE_HALF_TICKS)) begin
        tk_e.sgl_cnt = '0;
        if (tk_e.sgl_tog >= 8'(mlbpg_pkg::SINGLE_TOGGLES)) begin
          tk_e.sgl_tog = '0;
          tk_e.sgl_act = 1'b0;
        end else begin
          tk_e.sgl_tog = tk_e.sgl_tog + 8'd1;
          tk_pin       = ~tk_pin;
        end
      end
    end
    // double-blink burst
    if (tk_e.dbl_act) begin
      tk_e.dbl_cnt = tk_e.dbl_cnt + 16'd1;
      if (tk_e.dbl_cnt >= tk_e.dbl_ticks) begin
        tk_pin       = ~tk_pin;
        tk_e.dbl_cnt = '0;
        tk_e.dbl_tog = tk_e.dbl_tog + 8'd1;
        if (tk_e.dbl_tog >= 8'(mlbpg_pkg::DOUBLE_TOGGLES)) begin
          tk_e.dbl_act = 1'b0;
        end
      end
    end
    // pending period update
    if (apply_q && tk_e.pend_flag) begin
      tk_e.half_ticks = tk_e.pend_half;
      tk_e.dbl_ticks  = tk_e.pend_dbl;
      tk_e.sq_cnt     = '0;
      tk_e.dbl_cnt    = '0;
      tk_e.dbl_act    = 1'b0;
      tk_e.dbl_tog    = '0;
      tk_e.pend_flag  = 1'b0;
      if (mlbpg_pkg::is_constant(tk_e.half_ticks)) begin
        tk_pin = (tk_e.half_ticks == mlbpg_pkg::CONST_ON);
      end
    end
  end

  // Period command or blink request on one entry
  always_comb begin
    cm_e   = rd_entry;
    cm_pin = pin_q[cmd_addr];
    if (mode_q == mlbpg_pkg::MODE_PERIOD) begin
      if (mlbpg_pkg::is_constant(half_q)) begin
        cm_e.half_ticks = half_q;
        cm_e.dbl_ticks  = '0;
        cm_pin          = (half_q == mlbpg_pkg::CONST_ON);
      end else begin
        cm_e.pend_half = quo_half;
        cm_e.pend_dbl  = quo_dbl;
        cm_e.pend_flag = 1'b1;
      end
    end else if (!cm_e.sgl_act) begin
      cm_pin       = ~cm_pin;
      cm_e.sgl_cnt = '0;
      cm_e.sgl_tog = 8'd1;
      cm_e.sgl_act = 1'b1;
    end
  end

  // Next state and memory control
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cmd_idx_d    = cmd_idx_q;
    half_d       = half_q;
    div_d        = div_q;
    apply_d      = apply_q;
    n_d          = n_q;
    scan_d       = scan_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    out_valid_d  = out_valid_q;
    pin_levels_d = pin_levels_q;
    mem_re       = 1'b0;
    mem_raddr    = scan_q[IdxW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = tk_e;
    pin_we       = 1'b0;
    pin_wval     = tk_pin;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mlbpg_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d    = mode_i;
          cmd_idx_d = led_index_i;
          half_d    = half_period_ms_i;
          state_d   = mlbpg_pkg::ST_DONE;
          case (mode_i)
            mlbpg_pkg::MODE_TICK: begin
              if (running_q) begin
                n_d    = n_lim;
                scan_d = '0;
                if (div_inc >= 16'(mlbpg_pkg::UPDATE_TICKS)) begin
                  div_d   = '0;
                  apply_d = 1'b1;
                end else begin
                  div_d   = div_inc;
                  apply_d = 1'b0;
                end
                if (n_lim != '0) begin
                  state_d = mlbpg_pkg::ST_TICK;
                end
              end
            end
            mlbpg_pkg::MODE_PERIOD, mlbpg_pkg::MODE_BLINK: begin
              if (idx_ok) begin
                state_d = mlbpg_pkg::ST_CMD_RD;
              end
            end
            default: begin
              state_d = mlbpg_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Stream entries through the read port, write each back in the cycle after its read
      mlbpg_pkg::ST_TICK: begin
        if (scan_q < n_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IdxW-1:0];
          scan_d   = scan_q + CntW'(1);
        end else begin
          state_d = mlbpg_pkg::ST_DONE;
        end
        if (rd_vld_q) begin
          mem_we = 1'b1;
          pin_we = 1'b1;
        end
      end

      mlbpg_pkg::ST_CMD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cmd_addr;
        state_d   = mlbpg_pkg::ST_CMD_WR;
      end

      mlbpg_pkg::ST_CMD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_addr;
        mem_wdata = cm_e;
        pin_we    = 1'b1;
        pin_wval  = cm_pin;
        state_d   = mlbpg_pkg::ST_DONE;
      end

      // Hand the pin vector to the output register once it is free
      mlbpg_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          pin_levels_d = pin_vec;
          state_d      = mlbpg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mlbpg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlbpg_pkg::ST_IDLE;
      div_q        <= '0;
      apply_q      <= 1'b0;
      n_q          <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
      pin_q        <= '0;
      ent_vld_q    <= '0;
      rd_ent_vld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      apply_q     <= apply_d;
      n_q         <= n_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (pin_we) begin
        pin_q[mem_waddr] <= pin_wval;
      end
      if (mem_we) begin
        ent_vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_ent_vld_q <= ent_vld_q[mem_raddr];
      end
    end
  end

  // Payload registers; products for the ms-to-tick conversion
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    cmd_idx_q    <= cmd_idx_d;
    half_q       <= half_d;
    pin_levels_q <= pin_levels_d;
    if (accept) begin
      prod_half_q <= 48'(half_period_ms_i) * 48'(mlbpg_pkg::DIV_RECIP);
      prod_dbl_q  <= {32'(48'(double_blink_ms_i) * 48'(mlbpg_pkg::DIV_RECIP) >> 16),
                      double_blink_ms_i};
    end
  end

  // LED state memory: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      led_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= led_mem_q[mem_raddr];
    end
  end

  // Visible pins; bits at or above LED_COUNT read zero
  for (genvar g = 0; g < 16; g++) begin : g_pin
    if (g < LED_COUNT) begin : g_on
      assign pin_vec[g] = pin_q[g];
    end else begin : g_off
      assign pin_vec[g] = 1'b0;
    end
  end

`ifndef SYNTHESIS
  // Scan never runs past the LED count latched at acceptance
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlbpg_pkg::ST_TICK) |-> (scan_q <= n_q))
    else $error("tick scan past LED count");

  // Write-back only targets an entry that was read in this tick
  a_wb_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlbpg_pkg::ST_TICK && rd_vld_q) |-> (CntW'(rd_idx_q) < n_q))
    else $error("tick write-back index out of range");

  // Command read is always followed by its write-back
  a_cmd_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlbpg_pkg::ST_CMD_RD) |=> (state_q == mlbpg_pkg::ST_CMD_WR))
    else $error("command read without write-back");

  // A new result appears only when an item finishes
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == mlbpg_pkg::ST_DONE))
    else $error("result produced outside item completion");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for multi_led_blink_pattern_generator_top: directed and random items,
// predicted pin vectors checked in order against every result, with random stalls on both sides.
// Depends on mlbpg_pkg and the top level RTL.
module testbench;

  localparam int unsigned LEDS = mlbpg_pkg::LED_COUNT_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = mlbpg_pkg::MODE_TICK;
  logic [3:0]  led_index_i = '0;
  logic [15:0] half_period_ms_i = '0;
  logic [15:0] double_blink_ms_i = '0;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] pin_levels_o;

  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [mlbpg_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mlbpg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  multi_led_blink_pattern_generator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .led_index_i       (led_index_i),
    .half_period_ms_i  (half_period_ms_i),
    .double_blink_ms_i (double_blink_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pin_levels_o      (pin_levels_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Clock, period 4
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shared control between stimulus and result side
  logic [15:0] expected_pins[$];
  int          error_count = 0;
  bit          gaps_off = 1'b0;
  int          hold_request = 0;
  bit          in_held = 1'b0;

  // Shadow of the configuration registers
  logic [4:0] led_count_cfg = '0;
  bit         run_cfg = 1'b0;

  // Shadow of the generator state, zero after reset
  logic [15:0] div_count = '0;
  bit          pin_on     [LEDS];
  bit          square_hi  [LEDS];
  logic [15:0] half_ticks [LEDS];
  logic [15:0] dbl_ticks  [LEDS];
  logic [15:0] square_cnt [LEDS];
  bit          dbl_busy   [LEDS];
  logic [15:0] dbl_cnt    [LEDS];
  logic [7:0]  dbl_done   [LEDS];
  logic [15:0] pend_half  [LEDS];
  logic [15:0] pend_dbl   [LEDS];
  bit          pend_valid [LEDS];
  bit          shot_busy  [LEDS];
  logic [15:0] shot_cnt   [LEDS];
  logic [7:0]  shot_done  [LEDS];

  initial begin
    for (int i = 0; i < LEDS; i++) begin
      half_ticks[i] = '0; dbl_ticks[i] = '0; square_cnt[i] = '0; dbl_cnt[i] = '0;
      dbl_done[i] = '0; pend_half[i] = '0; pend_dbl[i] = '0; shot_cnt[i] = '0;
      shot_done[i] = '0;
    end
  end

  // Advance the shadow state by one item and return the pin vector it yields
  function automatic logic [15:0] predict_pins(input logic [1:0] mode, input logic [3:0] idx,
                                               input logic [15:0] half, input logic [15:0] dbl);
    int unsigned n;
    bit          apply;
    logic [15:0] pins;
    case (mode)
      mlbpg_pkg::MODE_TICK: begin
        if (run_cfg) begin
          n = (led_count_cfg > LEDS) ? LEDS : led_count_cfg;
          div_count = div_count + 16'd1;
          apply = (div_count >= mlbpg_pkg::UPDATE_TICKS);
          if (apply) div_count = '0;
          for (int i = 0; i < n; i++) begin
            // square wave, double burst armed on each rising toggle
            if (!(half_ticks[i] inside {mlbpg_pkg::CONST_OFF, mlbpg_pkg::CONST_ON})) begin
              square_cnt[i] = square_cnt[i] + 16'd1;
              if (square_cnt[i] >= half_ticks[i]) begin
                square_hi[i] = !square_hi[i];
                pin_on[i] = square_hi[i];
                square_cnt[i] = '0;
                if (dbl_ticks[i] != 0 && square_hi[i]) begin
                  dbl_busy[i] = 1'b1;
                  dbl_cnt[i] = '0;
                  dbl_done[i] = '0;
                end else begin
                  dbl_busy[i] = 1'b0;
                end
              end
            end
            // one-shot burst
            if (shot_busy[i]) begin
              shot_cnt[i] = shot_cnt[i] + 16'd1;
              if (shot_cnt[i] >= mlbpg_pkg::SINGLE_HALF_TICKS) begin
                shot_cnt[i] = '0;
                if (shot_done[i] >= mlbpg_pkg::SINGLE_TOGGLES) begin
                  shot_done[i] = '0;
                  shot_busy[i] = 1'b0;
                end else begin
                  shot_done[i] = shot_done[i] + 8'd1;
                  pin_on[i] = !pin_on[i];
                end
              end
            end
            // double burst
            if (dbl_busy[i]) begin
              dbl_cnt[i] = dbl_cnt[i] + 16'd1;
              if (dbl_cnt[i] >= dbl_ticks[i]) begin
                pin_on[i] = !pin_on[i];
                dbl_cnt[i] = '0;
                dbl_done[i] = dbl_done[i] + 8'd1;
                if (dbl_done[i] >= mlbpg_pkg::DOUBLE_TOGGLES) dbl_busy[i] = 1'b0;
              end
            end
            // pending period update
            if (apply && pend_valid[i]) begin
              half_ticks[i] = pend_half[i];
              dbl_ticks[i] = pend_dbl[i];
              square_cnt[i] = '0;
              dbl_cnt[i] = '0;
              dbl_busy[i] = 1'b0;
              dbl_done[i] = '0;
              pend_valid[i] = 1'b0;
              if (half_ticks[i] inside {mlbpg_pkg::CONST_OFF, mlbpg_pkg::CONST_ON})
                pin_on[i] = (half_ticks[i] == mlbpg_pkg::CONST_ON);
            end
          end
        end
      end
      mlbpg_pkg::MODE_PERIOD: begin
        if (idx < LEDS) begin
          if (half inside {mlbpg_pkg::CONST_OFF, mlbpg_pkg::CONST_ON}) begin
            half_ticks[idx] = half;
            dbl_ticks[idx] = '0;
            pin_on[idx] = (half == mlbpg_pkg::CONST_ON);
          end else begin
            pend_half[idx] = 16'(half / mlbpg_pkg::TICK_MS);
            pend_dbl[idx] = 16'(dbl / mlbpg_pkg::TICK_MS);
            pend_valid[idx] = 1'b1;
          end
        end
      end
      mlbpg_pkg::MODE_BLINK: begin
        if (idx < LEDS && !shot_busy[idx]) begin
          pin_on[idx] = !pin_on[idx];
          shot_cnt[idx] = '0;
          shot_done[idx] = 8'd1;
          shot_busy[idx] = 1'b1;
        end
      end
      default: ;
    endcase
    pins = '0;
    for (int i = 0; i < LEDS && i < 16; i++) pins[i] = pin_on[i];
    return pins;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until accepted, then record its prediction
  task automatic send_item(input logic [1:0] mode, input logic [3:0] idx,
                           input logic [15:0] half, input logic [15:0] dbl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (in_held) begin
        in_valid_i <= 1'b0;
        in_held = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= mode;
    led_index_i       <= idx;
    half_period_ms_i  <= half;
    double_blink_ms_i <= dbl;
    in_held = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pins.push_back(predict_pins(mode, idx, half, dbl));
  endtask

  // Random item, biased to short periods so the patterns actually run
  task automatic send_random_item();
    int          r;
    logic [1:0]  mode;
    logic [15:0] half;
    logic [15:0] dbl;
    r = $urandom_range(0, 99);
    half = 16'($urandom);
    dbl = 16'($urandom);
    if (r < 62) begin
      mode = mlbpg_pkg::MODE_TICK;
    end else if (r < 84) begin
      mode = mlbpg_pkg::MODE_PERIOD;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        half = 16'($urandom_range(10, 80));
        dbl = 16'($urandom_range(0, 40));
      end else if (r < 75) begin
        half = 16'($urandom_range(1, 9));
      end else if (r < 85) begin
        half = $urandom_range(0, 1) ? mlbpg_pkg::CONST_ON : mlbpg_pkg::CONST_OFF;
      end
    end else if (r < 97) begin
      mode = mlbpg_pkg::MODE_BLINK;
    end else begin
      mode = MODE_UNUSED;
    end
    send_item(mode, 4'($urandom_range(0, 15)), half, dbl);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    if (in_held) begin
      in_valid_i <= 1'b0;
      in_held = 1'b0;
      @(posedge clk_i);
    end
    do @(posedge clk_i); while (expected_pins.size() != 0);
  endtask

  // Write both registers back to back; only called while the block is idle
  task automatic set_config(input logic [4:0] count, input bit run);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= mlbpg_pkg::CFG_ACTIVE_LED_COUNT;
    cfg_data_i  <= mlbpg_pkg::CFG_DATA_W'(count);
    do @(posedge clk_i); while (!cfg_ready_o);
    led_count_cfg = count;
    cfg_index_i <= mlbpg_pkg::CFG_RUNNING;
    cfg_data_i  <= mlbpg_pkg::CFG_DATA_W'(run);
    do @(posedge clk_i); while (!cfg_ready_o);
    run_cfg = run;
    cfg_valid_i <= 1'b0;
  endtask

  // Ticks while stopped and the unused mode change nothing
  task automatic test_ignored_inputs();
    set_config(5'd0, 1'b0);
    send_item(mlbpg_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
    send_item(MODE_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF);
  endtask

  // Constant periods and blink requests act at once, even on unprocessed LEDs
  task automatic test_immediate_commands();
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd15, mlbpg_pkg::CONST_ON, 16'd0);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd1, mlbpg_pkg::CONST_ON, 16'hFFFF);
    send_item(mlbpg_pkg::MODE_BLINK, 4'd7, 16'd0, 16'd0);
    // second request while the burst runs is dropped
    send_item(mlbpg_pkg::MODE_BLINK, 4'd7, 16'd0, 16'd0);
  endtask

  // Pending periods land on the update tick; sub-tick period turns the LED off
  task automatic test_pending_update();
    wait_idle();
    set_config(5'd16, 1'b1);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd0, 16'd20, 16'd10);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd1, 16'd9, 16'hFFFF);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd2, 16'hFFFE, 16'd0);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd15, mlbpg_pkg::CONST_OFF, 16'd0);
    repeat (mlbpg_pkg::UPDATE_TICKS) send_item(mlbpg_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
  endtask

  // Constant-on command in the middle of a double burst leaves the burst running
  task automatic test_constant_in_burst();
    repeat (2) send_item(mlbpg_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
    send_item(mlbpg_pkg::MODE_PERIOD, 4'd0, mlbpg_pkg::CONST_ON, 16'd0);
    repeat (2) send_item(mlbpg_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
  endtask

  // Random items over a range of LED counts, with the run bit both ways
  task automatic test_random_traffic();
    logic [4:0] count;
    bit         run;
    for (int p = 0; p < 8; p++) begin
      run = 1'b1;
      case (p)
        0: count = 5'd16;
        1: count = 5'd31;
        2: count = 5'($urandom_range(2, 15));
        3: begin count = 5'd16; run = 1'b0; end
        4: count = 5'd0;
        5: count = 5'd1;
        6: count = 5'($urandom_range(17, 30));
        default: count = 5'd16;
      endcase
      wait_idle();
      set_config(count, run);
      gaps_off = (p == 6);
      repeat (190) send_random_item();
    end
    gaps_off = 1'b0;
  endtask

  // Long receiver hold while the sender keeps going, so the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    set_config(5'd16, 1'b1);
    hold_request = 300;
    gaps_off = 1'b1;
    repeat (60) send_random_item();
    gaps_off = 1'b0;
  endtask

  // Sender stops until the block has drained, then resumes
  task automatic test_sender_pause();
    repeat (30) send_random_item();
    wait_idle();
    repeat (30) send_random_item();
  endtask

  // Result side: random stalls, long hold on request, in-order compare
  initial begin : result_check
    int          stall_left;
    logic [15:0] want;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_pins.size() == 0) begin
          $display("%0t: unexpected item, pin_levels %h", $time, pin_levels_o);
          error_count++;
        end else begin
          want = expected_pins.pop_front();
          if (pin_levels_o !== want) begin
            $display("%0t: pin_levels expected %h actual %h", $time, want, pin_levels_o);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!gaps_off && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ignored_inputs();
    test_immediate_commands();
    test_pending_update();
    test_constant_in_burst();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    // allow a stray late result to show up
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
